// ===== sv/lcg_keystream_packet_cipher_unit_defines.svh =====
// assertion macros shared by the cipher unit rtl
// no dependencies; included by the modules that carry assertions
`ifndef LCG_KEYSTREAM_PACKET_CIPHER_UNIT_DEFINES_SVH
`define LCG_KEYSTREAM_PACKET_CIPHER_UNIT_DEFINES_SVH

// condition holds at every edge outside reset
`define LCGK_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LCGK_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define LCGK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lcgk_pkg.sv =====
// shared types and constants of the lcg keystream cipher unit
// no dependencies
package lcgk_pkg;

  // lcg multiplier for the keystream iterator
  localparam logic [31:0] LCG_MULT = 32'h0808_8405;

  // per-packet block limits
  localparam logic [3:0] LIMIT_PLAIN  = 4'd12;
  localparam logic [3:0] LIMIT_PACKED = 4'd4;

  // compression kinds
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_ZLIB  = 2'd1;
  localparam logic [1:0] KIND_BZ2   = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'b1;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } lcgk_item_t;

  // one input item
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       first;
    logic       last;
  } lcgk_in_t;

endpackage

// ===== sv/lcgk_core.sv =====
// keystream state and per-byte xor for the cipher unit
// depends on lcgk_pkg and the shared assertion macro header
`include "lcg_keystream_packet_cipher_unit_defines.svh"

module lcgk_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lcgk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          in_fire,
  input  lcgk_pkg::lcgk_in_t            in_item,
  output lcgk_pkg::lcgk_item_t          res_item
);
  import lcgk_pkg::*;

  logic [7:0]  key_r;
  logic [31:0] iter_r, iter_nxt;
  logic [1:0]  lane_r, lane_nxt;
  logic [3:0]  blk_r, blk_nxt;
  logic        lim_r, lim_nxt;
  logic        unl_r, unl_nxt;

  logic [1:0]  lane_cur;
  logic [3:0]  blk_cur;
  logic        lim_cur;
  logic        unl_cur;
  logic        at_block;
  logic        stop;
  logic        adv;
  logic [31:0] iter_prod;
  logic [7:0]  ks_byte;

  // packet start restarts counters and latches the block limit
  always_comb begin
    lane_cur = in_item.first ? 2'd0 : lane_r;
    lim_cur  = in_item.first ? 1'b0 : lim_r;
    unl_cur  = in_item.first ? (in_item.kind == KIND_OTHER) : unl_r;
    blk_cur  = blk_r;
    if (in_item.first) begin
      unique case (in_item.kind)
        KIND_PLAIN: blk_cur = LIMIT_PLAIN;
        KIND_OTHER: blk_cur = 4'd0;
        default:    blk_cur = LIMIT_PACKED;
      endcase
    end
  end

  // block boundary: either advance the iterator or hit the limit
  assign at_block  = !lim_cur && (lane_cur == 2'd0);
  assign stop      = at_block && !unl_cur && (blk_cur == 4'd0);
  assign adv       = at_block && !stop;
  assign iter_prod = iter_r * LCG_MULT;

  always_comb begin
    lim_nxt  = lim_cur || stop;
    unl_nxt  = unl_cur;
    iter_nxt = adv ? (iter_prod + {24'd0, key_r}) : iter_r;
    blk_nxt  = (adv && !unl_cur) ? (blk_cur - 4'd1) : blk_cur;
    lane_nxt = lim_nxt ? lane_cur : (lane_cur + 2'd1);
  end

  // lane select and xor
  assign ks_byte       = iter_nxt[{lane_cur, 3'b000} +: 8];
  assign res_item.data = lim_nxt ? in_item.data : (in_item.data ^ ks_byte);
  assign res_item.last = in_item.last;

  // state registers; the user must issue config writes only while idle, this block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= 8'd0;
      iter_r <= 32'd0;
      lane_r <= 2'd0;
      blk_r  <= 4'd0;
      lim_r  <= 1'b0;
      unl_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_KEY:  key_r  <= cfg_wdata[7:0];
        CFG_SEED: iter_r <= cfg_wdata;
        default:  ;
      endcase
    end else if (in_fire) begin
      iter_r <= iter_nxt;
      lane_r <= lane_nxt;
      blk_r  <= blk_nxt;
      lim_r  <= lim_nxt;
      unl_r  <= unl_nxt;
    end
  end

  // checks
  `LCGK_ASSERT_ALWAYS(a_blk_range, clk, rst_n, blk_r <= LIMIT_PLAIN, "block count out of range")
  `LCGK_ASSERT_SAME(a_lim_pass, clk, rst_n, in_fire && lim_r && !in_item.first, res_item.data == in_item.data, "byte altered past limit")
  `LCGK_ASSERT_NEXT(a_lim_hold, clk, rst_n, in_fire && !cfg_wr_en && lim_r && !in_item.first, $stable(iter_r) && $stable(lane_r), "state moved past limit")

endmodule

// ===== sv/lcgk_obuf.sv =====
// two-entry result buffer between the cipher core and the output channel
// depends on lcgk_pkg and the shared assertion macro header
`include "lcg_keystream_packet_cipher_unit_defines.svh"

module lcgk_obuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lcgk_pkg::lcgk_item_t push_item,
  output logic                 can_push,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output lcgk_pkg::lcgk_item_t pop_item
);
  import lcgk_pkg::*;

  lcgk_item_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign can_push  = (count_r != 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  // checks
  `LCGK_ASSERT_ALWAYS(a_cnt_range, clk, rst_n, count_r != 2'd3, "buffer count overflow")
  `LCGK_ASSERT_NEXT(a_fill_shows, clk, rst_n, push && !pop_valid, pop_valid && (pop_item == $past(push_item)), "pushed item not at head")
  `LCGK_ASSERT_ALWAYS(a_ptr_match, clk, rst_n, (count_r == 2'd1) == (wr_ptr_r != rd_ptr_r), "pointers disagree with count")

endmodule

// ===== sv/lcg_keystream_packet_cipher_unit.sv =====
// top level of the lcg keystream packet cipher unit
// depends on lcgk_pkg, lcgk_core and lcgk_obuf

// Encrypts or decrypts one payload byte per cycle while the output buffer has
// room: every accepted byte gets one result byte, XORed with one lane of a
// 32-bit lcg iterator that steps (iterator * 0x08088405 + key) at each 4-byte
// block boundary. The block limit per packet follows the compression kind
// sampled on the first byte (12 for uncompressed, 4 for zlib or bz2, none
// otherwise); later bytes pass through. The state update and xor are one
// combinational pass whose long path is the single 32x32 constant multiply
// feeding back into the iterator register. Results are registered in a
// two-entry output buffer, so input keeps flowing while a result waits.
// Writing the seed register loads the running iterator; write configuration
// only while no transfer is in flight.
module lcg_keystream_packet_cipher_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [lcgk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,  // [7:0] data_byte
  input  logic [2:0]                     in_tuser,  // [1:0] comp_kind, [2] first_of_packet
  input  logic                           in_tlast,  // last_of_packet
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata, // [7:0] out_byte
  output logic                           out_tlast  // out_last
);
  import lcgk_pkg::*;

  lcgk_in_t   in_item;
  lcgk_item_t res_item;
  lcgk_item_t head_item;
  logic       in_fire;
  logic       can_push;

  // input unpack
  assign in_item.data  = in_tdata;
  assign in_item.kind  = in_tuser[1:0];
  assign in_item.first = in_tuser[2];
  assign in_item.last  = in_tlast;

  assign in_tready = can_push;
  assign in_fire   = in_tvalid && can_push;

  // keystream state and xor
  lcgk_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .res_item  (res_item)
  );

  // result buffer
  lcgk_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_item (res_item),
    .can_push  (can_push),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_item  (head_item)
  );

  assign out_tdata = head_item.data;
  assign out_tlast = head_item.last;

endmodule

// ===== sim/lcgk_cipher_checker.sv =====
// checker for the lcg keystream packet cipher unit: predicts every result byte
// from the input and configuration transfers and compares the result stream
// depends on lcgk_pkg
module lcgk_cipher_checker
  import lcgk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  input  logic [2:0]           in_tuser,   // [1:0] comp_kind, [2] first_of_packet
  input  logic                 in_tlast,   // last_of_packet
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [7:0]           out_tdata,  // [7:0] out_byte
  input  logic                 out_tlast,  // out_last
  output int unsigned          mismatch_count,
  output int unsigned          bytes_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // cipher state mirrored from the block
  logic [7:0]  key_r;
  logic [31:0] iter_r;
  logic [1:0]  lane_r;
  logic [3:0]  blocks_left_r;
  logic        halted_r;
  logic        unlimited_r;

  // result bytes still owed by the block, oldest first
  lcgk_item_t  cipher_bytes_due[$];
  lcgk_item_t  want;
  lcgk_in_t    byte_in;

  // one byte through the keystream, updating the mirrored state
  function automatic lcgk_item_t keystream_xor(input lcgk_in_t b);
    lcgk_item_t r;
    r.data = b.data;
    r.last = b.last;
    // packet start: restart counts and latch the block limit
    if (b.first) begin
      lane_r      = 2'd0;
      halted_r    = 1'b0;
      unlimited_r = (b.kind == KIND_OTHER);
      case (b.kind)
        KIND_PLAIN: blocks_left_r = LIMIT_PLAIN;
        KIND_OTHER: blocks_left_r = 4'd0;
        default:    blocks_left_r = LIMIT_PACKED;
      endcase
    end
    // block boundary: advance the iterator or stop for the rest of the packet
    if (!halted_r && lane_r == 2'd0) begin
      if (!unlimited_r && blocks_left_r == 4'd0) begin
        halted_r = 1'b1;
      end else begin
        iter_r = iter_r * LCG_MULT + {24'd0, key_r};
        if (!unlimited_r) blocks_left_r = blocks_left_r - 4'd1;
      end
    end
    if (!halted_r) begin
      r.data = b.data ^ iter_r[lane_r*8 +: 8];
      lane_r = lane_r + 2'd1;
    end
    return r;
  endfunction

  // watch configuration, input and result transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      key_r          = '0;
      iter_r         = '0;
      lane_r         = '0;
      blocks_left_r  = '0;
      halted_r       = 1'b0;
      unlimited_r    = 1'b0;
      mismatch_count = 0;
      cipher_bytes_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_KEY:  key_r  = cfg_wdata[7:0];
          CFG_SEED: iter_r = cfg_wdata;
          default: ;
        endcase
      end
      // result transfer against the oldest byte due
      if (out_tvalid && out_tready) begin
        if (cipher_bytes_due.size() == 0) begin
          $error("result transfer with no byte due: out_byte %h out_last %b",
                 out_tdata, out_tlast);
          mismatch_count++;
        end else begin
          want = cipher_bytes_due.pop_front();
          if (out_tdata !== want.data) begin
            $error("out_byte mismatch: expected %h, actual %h", want.data, out_tdata);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $error("out_last mismatch: expected %b, actual %b", want.last, out_tlast);
            mismatch_count++;
          end
        end
      end
      // input transfer
      if (in_tvalid && in_tready) begin
        byte_in.data  = in_tdata;
        byte_in.kind  = in_tuser[1:0];
        byte_in.first = in_tuser[2];
        byte_in.last  = in_tlast;
        cipher_bytes_due = {cipher_bytes_due, keystream_xor(byte_in)};
      end
    end
    bytes_due <= cipher_bytes_due.size();
  end

endmodule

// ===== sim/tb_lcg_keystream_packet_cipher_unit.sv =====
// testbench top for the lcg keystream packet cipher unit: drives packets and
// register writes with random idling and gives the verdict
// depends on lcgk_pkg, lcg_keystream_packet_cipher_unit and lcgk_cipher_checker
module tb_lcg_keystream_packet_cipher_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lcgk_pkg::*;

  localparam int ITEMS_TOTAL = 1650;
  localparam int ITEMS_CALM  = 1400;

  // packet shapes
  localparam int PKT_CLEAN    = 0;
  localparam int PKT_NO_LAST  = 1;
  localparam int PKT_NO_FIRST = 2;
  localparam int PKT_NOISE    = 3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // [7:0] data_byte
  logic [2:0]           in_tuser;   // [1:0] comp_kind, [2] first_of_packet
  logic                 in_tlast;   // last_of_packet
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;  // [7:0] out_byte
  logic                 out_tlast;  // out_last

  int unsigned mismatch_count;
  int unsigned bytes_due;
  int unsigned items_sent;
  int          gap_pct;
  int          stall_pct;
  bit          calm;

  lcg_keystream_packet_cipher_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  lcgk_cipher_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .bytes_due      (bytes_due)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side stalls in bursts
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // one input transfer, after an optional idle burst
  task automatic send_byte(input logic [7:0] d, input logic [1:0] k,
                           input logic f, input logic l);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= {f, k};
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // one packet of random bytes; later bytes carry random kinds
  task automatic send_packet(input logic [1:0] kind, input int len, input int shape);
    logic       f;
    logic       l;
    logic [1:0] k;
    for (int i = 0; i < len; i++) begin
      f = (i == 0);
      l = (i == len - 1);
      k = f ? kind : 2'($urandom_range(0, 3));
      case (shape)
        PKT_NO_LAST:  l = 1'b0;
        PKT_NO_FIRST: f = 1'b0;
        PKT_NOISE: begin
          f = ($urandom_range(0, 7) == 0);
          l = ($urandom_range(0, 7) == 0);
        end
        default: ;
      endcase
      send_byte(8'($urandom), k, f, l);
    end
  endtask

  // hold input until every result has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // stimulus and verdict
  initial begin
    int          phase;
    int unsigned phase_end;
    int          pick;
    int          len;
    int          shape;
    logic [1:0]  kind;

    rst_n      <= 1'b0;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    in_tlast   <= 1'b0;
    items_sent = 0;
    gap_pct    = 20;
    stall_pct  = 20;
    calm       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes ahead of any packet start pass through
    send_byte(8'h00, KIND_PLAIN, 1'b0, 1'b0);
    send_byte(8'hff, KIND_OTHER, 1'b0, 1'b1);
    drain_results();
    write_reg(CFG_KEY, 32'h0000_00ff);
    write_reg(CFG_SEED, 32'hffff_ffff);

    // zlib packet running past its four blocks, kind changing on later bytes
    for (int i = 0; i < 18; i++)
      send_byte((i == 0) ? 8'hff : (i == 1) ? 8'h00 : 8'($urandom),
                (i == 0) ? KIND_ZLIB : 2'(i), i == 0, i == 17);
    // single-byte bz2 packet, then an unlimited one with a straggler byte
    send_byte(8'h00, KIND_BZ2, 1'b1, 1'b1);
    send_byte(8'hff, KIND_OTHER, 1'b1, 1'b0);
    send_byte(8'h5a, KIND_PLAIN, 1'b0, 1'b0);
    send_byte(8'ha5, KIND_ZLIB, 1'b0, 1'b1);
    send_byte(8'h3c, KIND_BZ2, 1'b0, 1'b0);

    // random phases, registers rewritten while idle between them
    phase = 0;
    while (items_sent < ITEMS_TOTAL) begin
      drain_results();
      if (phase == 0) begin
        write_reg(CFG_KEY, 32'h0);
        write_reg(CFG_SEED, 32'h0);
      end else begin
        pick = $urandom_range(0, 2);
        if (pick != 1)
          write_reg(CFG_KEY, ($urandom_range(0, 3) == 0) ? 32'hff : 32'($urandom_range(0, 255)));
        if (pick != 0)
          write_reg(CFG_SEED, ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom);
      end
      if (items_sent >= ITEMS_CALM) begin
        calm      = 1'b1;
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 10 * $urandom_range(0, 3);
        stall_pct = 10 * $urandom_range(0, 3);
      end
      phase_end = items_sent + 220;
      while (items_sent < phase_end && items_sent < ITEMS_TOTAL) begin
        kind = 2'($urandom_range(0, 3));
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 24);
        pick = $urandom_range(0, 99);
        shape = (pick < 80) ? PKT_CLEAN : (pick < 87) ? PKT_NO_LAST :
                (pick < 93) ? PKT_NO_FIRST : PKT_NOISE;
        send_packet(kind, len, shape);
      end
      phase++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && bytes_due == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
